FILE: design/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and lead-byte helpers of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W         = 8;
  localparam int CP_W           = 21;
  localparam int CNT_W          = 3;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

  // Sequence lengths announced by a lead byte.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // One request from the classifier: count results, all but the last are
  // replacement characters.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CP_W-1:0]  last_cp;
    logic             last_rep;
    logic             text_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = LEN_1;
    end else if (b[7:5] == 3'b110) begin
      len = LEN_2;
    end else if (b[7:4] == 4'b1110) begin
      len = LEN_3;
    end else if (b[7:3] == 5'b11110) begin
      len = LEN_4;
    end else begin
      len = LEN_NONE;
    end
    return len;
  endfunction

  function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                   input logic [2:0] len);
    logic [CP_W-1:0] v;
    case (len)
      LEN_2:   v = {16'b0, b[4:0]};
      LEN_3:   v = {17'b0, b[3:0]};
      LEN_4:   v = {18'b0, b[2:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CP_W-1:0] min_value(input logic [2:0] len);
    logic [CP_W-1:0] v;
    case (len)
      LEN_2:   v = 21'h000080;
      LEN_3:   v = 21'h000800;
      LEN_4:   v = 21'h010000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// UTF-8 to code point decoder with U+FFFD replacement of malformed input.
// ----------------------------------------------------------------------------
// The decoder takes one text byte per cycle while the request queue is not full
// and emits Unicode scalar values. A byte that flushes a broken sequence yields
// up to four results, which the output register sends one code point per cycle
// while out_tready is high. A queue of FIFO_DEPTH requests between the byte
// classifier and the result sequencer absorbs such bursts before the input
// stalls. The request of an accepted byte passes through the queue and then the
// output register before its first result appears.
module utf8_byte_stream_decoder
  import utf8d_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [21] text_done, [23:22] zero
  output logic        out_tuser,  // [0] replaced
  output logic        out_tlast   // last_of_run
);

  fifo_stat_t      fifo_stat;
  cmd_t            wr_cmd, head;
  logic            push, pop;
  logic [CP_W-1:0] cp;
  logic            done;

  utf8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .cmd       (wr_cmd)
  );

  utf8d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (head),
    .stat   (fifo_stat)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cp    (cp),
    .out_rep   (out_tuser),
    .out_last  (out_tlast),
    .out_done  (done)
  );

  assign out_tdata = {2'b00, done, cp};

  // The end of the text can only fall on the final result of a byte.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tlast)
    else $error("text_done without last_of_run");

  // A replaced result always carries the replacement character.
  a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[20:0] == REPL_CP)
    else $error("replaced result with wrong code point");

  // Decoded values are scalar values: in range and not a surrogate.
  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[20:0] <= MAX_CP) &&
      ((out_tdata[20:0] < SURR_LO) || (out_tdata[20:0] > SURR_HI)))
    else $error("decoded value is not a scalar value");

  // The queue never overflows or underflows.
  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_stat.full) && !(pop && fifo_stat.empty))
    else $error("request queue overflow or underflow");

endmodule

FILE: design/utf8d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts text bytes, tracks the pending sequence and issues one result
// request per byte that produces output.
// ----------------------------------------------------------------------------
module utf8d_front
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end,
  input  fifo_stat_t        fifo_stat,
  output logic              push,
  output cmd_t              cmd
);

  logic [1:0]      held_r, held_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            accept;

  assign in_ready = ~fifo_stat.full;
  assign accept   = in_valid & in_ready;

  always_comb begin
    logic            hold_ok;
    logic [2:0]      len;
    logic            f;
    logic            fhold;
    logic [CP_W-1:0] fcp;
    logic            frep;
    logic [2:0]      k;
    logic [2:0]      c;
    logic [CP_W-1:0] v;
    logic            ok;
    logic            use_fresh;

    hold_ok = (held_r != 2'd0) && (exp_r >= LEN_2) && (exp_r <= LEN_4) &&
              ({1'b0, held_r} < exp_r);

    // Result of reading the byte as a new lead.
    len   = lead_length(in_byte);
    f     = 1'b1;
    fhold = 1'b0;
    fcp   = REPL_CP;
    frep  = 1'b1;
    if (len == LEN_NONE) begin
      fcp  = REPL_CP;
      frep = 1'b1;
    end else if (len == LEN_1) begin
      fcp  = {13'b0, in_byte};
      frep = 1'b0;
    end else if (in_end) begin
      fcp  = REPL_CP;
      frep = 1'b1;
    end else begin
      f     = 1'b0;
      fhold = 1'b1;
    end

    c  = {1'b0, held_r} + 3'd1;
    v  = {part_r[CP_W-7:0], in_byte[5:0]};
    ok = (v >= min_value(exp_r)) && (v <= MAX_CP) && ((v < SURR_LO) || (v > SURR_HI));

    k         = 3'd0;
    use_fresh = 1'b0;
    held_nxt  = 2'd0;
    exp_nxt   = LEN_NONE;
    part_nxt  = '0;
    cmd.count    = 3'd0;
    cmd.last_cp  = REPL_CP;
    cmd.last_rep = 1'b1;
    cmd.text_end = in_end;

    if (!hold_ok) begin
      use_fresh = 1'b1;
    end else if (in_byte[7:6] == 2'b10) begin
      if (c == exp_r) begin
        if (ok) begin
          cmd.count    = 3'd1;
          cmd.last_cp  = v;
          cmd.last_rep = 1'b0;
        end else begin
          cmd.count = c;
        end
      end else if (in_end) begin
        cmd.count = c;
      end else begin
        held_nxt = c[1:0];
        exp_nxt  = exp_r;
        part_nxt = v;
      end
    end else begin
      // A non-continuation byte breaks the sequence: flush, then re-read it.
      k         = {1'b0, held_r};
      use_fresh = 1'b1;
    end

    if (use_fresh) begin
      cmd.count = k + {2'b0, f};
      if (f) begin
        cmd.last_cp  = fcp;
        cmd.last_rep = frep;
      end
      if (fhold) begin
        held_nxt = 2'd1;
        exp_nxt  = len;
        part_nxt = lead_payload(in_byte, len);
      end
    end
  end

  assign push = accept && (cmd.count != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
      exp_r  <= LEN_NONE;
      part_r <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
      exp_r  <= exp_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

FILE: design/utf8d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_fifo
// Small request queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module utf8d_fifo
  import utf8d_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       wr_cmd,
  input  logic       pop,
  output cmd_t       rd_cmd,
  output fifo_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r;

  assign stat.empty = (level_r == '0);
  assign stat.full  = (level_r == LVL_W'(DEPTH));
  assign rd_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/utf8d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_back
// Expands queued requests into code point results, one per cycle while
// out_ready is high, through an output register.
// ----------------------------------------------------------------------------
module utf8d_back
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            head,
  input  fifo_stat_t      fifo_stat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_cp,
  output logic            out_rep,
  output logic            out_last,
  output logic            out_done
);

  logic            valid_r;
  logic [1:0]      idx_r;
  logic [CP_W-1:0] cp_r;
  logic            rep_r, last_r, done_r;
  logic            load, is_last;

  assign load    = !fifo_stat.empty && (!valid_r || out_ready);
  assign is_last = ({1'b0, idx_r} == (head.count - 3'd1));
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= is_last ? head.last_cp : REPL_CP;
      rep_r  <= is_last ? head.last_rep : 1'b1;
      last_r <= is_last;
      done_r <= is_last && head.text_end;
    end
  end

  assign out_valid = valid_r;
  assign out_cp    = cp_r;
  assign out_rep   = rep_r;
  assign out_last  = last_r;
  assign out_done  = done_r;

endmodule
